// File: rtl/rpc_hdr_pkg.sv
// ----------------------------------------------------------------------------
// rpc_hdr_pkg
// Shared widths, field codes and result types for the ONC RPC header parser.
// ----------------------------------------------------------------------------
`default_nettype none

package rpc_hdr_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned CODE_W   = 5;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned VB_W     = 3;
  localparam int unsigned SKIP_W   = 30;

  localparam int unsigned DEF_MAX_MESSAGE_BYTES = 65536;

  localparam logic [SKIP_W-1:0] SKIP_CAP    = '1;
  localparam logic [WORD_W-1:0] RPC_VERSION = 32'd2;

  // message type, reply, accept and reject status codes
  localparam logic [WORD_W-1:0] MSG_CALL         = 32'd0;
  localparam logic [WORD_W-1:0] MSG_REPLY        = 32'd1;
  localparam logic [WORD_W-1:0] REPLY_ACCEPTED   = 32'd0;
  localparam logic [WORD_W-1:0] REPLY_DENIED     = 32'd1;
  localparam logic [WORD_W-1:0] ACCEPT_PROG_MISM = 32'd2;
  localparam logic [WORD_W-1:0] REJECT_RPC_MISM  = 32'd0;
  localparam logic [WORD_W-1:0] REJECT_AUTH_ERR  = 32'd1;

  // result field codes
  localparam logic [CODE_W-1:0] FC_XID        = 5'd0;
  localparam logic [CODE_W-1:0] FC_MTYPE      = 5'd1;
  localparam logic [CODE_W-1:0] FC_RPCVERS    = 5'd2;
  localparam logic [CODE_W-1:0] FC_PROG       = 5'd3;
  localparam logic [CODE_W-1:0] FC_VERS       = 5'd4;
  localparam logic [CODE_W-1:0] FC_PROC       = 5'd5;
  localparam logic [CODE_W-1:0] FC_CRED_FLAV  = 5'd6;
  localparam logic [CODE_W-1:0] FC_CRED_LEN   = 5'd7;
  localparam logic [CODE_W-1:0] FC_VERF_FLAV  = 5'd8;
  localparam logic [CODE_W-1:0] FC_VERF_LEN   = 5'd9;
  localparam logic [CODE_W-1:0] FC_REPLY_STAT = 5'd10;
  localparam logic [CODE_W-1:0] FC_AVERF_FLAV = 5'd11;
  localparam logic [CODE_W-1:0] FC_AVERF_LEN  = 5'd12;
  localparam logic [CODE_W-1:0] FC_ACC_STAT   = 5'd13;
  localparam logic [CODE_W-1:0] FC_PROG_LOW   = 5'd14;
  localparam logic [CODE_W-1:0] FC_PROG_HIGH  = 5'd15;
  localparam logic [CODE_W-1:0] FC_REJ_STAT   = 5'd16;
  localparam logic [CODE_W-1:0] FC_VERS_LOW   = 5'd17;
  localparam logic [CODE_W-1:0] FC_VERS_HIGH  = 5'd18;
  localparam logic [CODE_W-1:0] FC_AUTH_STAT  = 5'd19;
  localparam logic [CODE_W-1:0] FC_PAYLOAD    = 5'd20;
  localparam logic [CODE_W-1:0] FC_END        = 5'd21;

  // end status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_TRUNC   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_STOPPED = 2'd2;

  typedef struct packed {
    logic [CODE_W-1:0]   field_code;
    logic [WORD_W-1:0]   field_value;
    logic [STATUS_W-1:0] status;
    logic                message_end;
  } result_t;

endpackage

`default_nettype wire

// File: rtl/rpc_hdr_in_if.sv
// ----------------------------------------------------------------------------
// rpc_hdr_in_if
// Message word channel into the header parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpc_hdr_in_if;
  import rpc_hdr_pkg::*;

  logic              valid;
  logic              ready;
  logic [WORD_W-1:0] word;
  logic              final_req;
  logic [VB_W-1:0]   valid_bytes;

  modport source (output valid, output word, output final_req, output valid_bytes,
                  input ready);
  modport sink   (input valid, input word, input final_req, input valid_bytes,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/rpc_hdr_out_if.sv
// ----------------------------------------------------------------------------
// rpc_hdr_out_if
// Parsed field channel out of the header parser.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpc_hdr_out_if;
  import rpc_hdr_pkg::*;

  logic                valid;
  logic                ready;
  logic [CODE_W-1:0]   field_code;
  logic [WORD_W-1:0]   field_value;
  logic [STATUS_W-1:0] status;
  logic                message_end;

  modport source (output valid, output field_code, output field_value, output status,
                  output message_end, input ready);
  modport sink   (input valid, input field_code, input field_value, input status,
                  input message_end, output ready);
endinterface

`default_nettype wire

// File: rtl/rpc_message_header_parser_unit.sv
// ----------------------------------------------------------------------------
// rpc_message_header_parser_unit
// ONC RPC message header parser: one word per transaction in, tagged header
// fields, payload words and an end-of-message record out.
// ----------------------------------------------------------------------------
//
//   channel   dir   payload                                        role
//   in_ch     in    word, final_req, valid_bytes                   message words
//   out_ch    out   field_code, field_value, status, message_end   parsed fields
//
// One word is taken per cycle while the result queue has room for two entries.
// A word goes through an input register, the parse step and into a four-entry
// result queue.
// A last word that also yields a field pushes two queue entries: the field and the end record.
// Reset empties the queue and returns the parser to the start of a message.
// A stall on out_ch fills the queue and then holds off in_ch.
`default_nettype none

module rpc_message_header_parser_unit #(
  parameter int unsigned MAX_MESSAGE_BYTES = rpc_hdr_pkg::DEF_MAX_MESSAGE_BYTES
) (
  input  logic           clk,
  input  logic           rst_n,
  rpc_hdr_in_if.sink     in_ch,
  rpc_hdr_out_if.source  out_ch
);
  import rpc_hdr_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_MESSAGE_BYTES / 4);
  localparam logic [CNT_W-1:0] WORD_CAP = CNT_W'(MAX_MESSAGE_BYTES / 4 - 1);
  localparam int unsigned TOT_W = CNT_W + 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W = PTR_W + 1;

  typedef enum logic [4:0] {
    P_XID, P_MTYPE, P_RPCVERS, P_PROG, P_VERS, P_PROC,
    P_CFLAV, P_CLEN, P_CSKIP, P_VFLAV, P_VLEN, P_VSKIP,
    P_STAT, P_AFLAV, P_ALEN, P_ASKIP, P_ASTAT, P_PLOW, P_PHIGH,
    P_RSTAT, P_RLOW, P_RHIGH, P_AUTH, P_BODY, P_STOP
  } pos_t;

  // input register
  logic              in_v_r;
  logic [WORD_W-1:0] word_r;
  logic              fin_r;
  logic [VB_W-1:0]   vb_r;

  // parse state
  pos_t              pos_r;
  logic [SKIP_W-1:0] skip_r;
  logic [CNT_W-1:0]  words_r;
  logic [CNT_W-1:0]  hw_r;

  // result queue
  result_t           queue_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [QCNT_W-1:0] qcnt_r;

  logic              proc;
  logic              pop;
  logic [VB_W-1:0]   vb_eff;
  logic              is_hdr;
  logic              is_skip;
  logic              trunc;
  logic              emit_fld;
  logic              hdr_step;
  logic [CODE_W-1:0] fld_code;
  pos_t              pos_adv;
  pos_t              len_skip;
  pos_t              len_next;
  logic              len_load;
  logic [SKIP_W:0]   ow_raw;
  logic [SKIP_W-1:0] ow;
  logic [SKIP_W-1:0] skip_dec;
  pos_t              pos_new;
  logic [SKIP_W-1:0] skip_new;
  logic [CNT_W-1:0]  hw_new;
  logic [TOT_W-1:0]  total;
  logic [TOT_W-1:0]  head;
  logic [TOT_W-1:0]  rem;
  result_t           fld_item;
  result_t           end_item;
  result_t           item_a;
  logic [1:0]        n_push;
  logic [QCNT_W-1:0] qcnt_nxt;

  assign proc = in_v_r && (qcnt_r <= QCNT_W'(QUEUE_DEPTH - 2));
  assign pop  = out_ch.valid && out_ch.ready;
  assign in_ch.ready = !in_v_r || proc;

  assign out_ch.valid       = (qcnt_r != '0);
  assign out_ch.field_code  = queue_r[rd_ptr_r].field_code;
  assign out_ch.field_value = queue_r[rd_ptr_r].field_value;
  assign out_ch.status      = queue_r[rd_ptr_r].status;
  assign out_ch.message_end = queue_r[rd_ptr_r].message_end;

  // opaque body length in words, rounded up and saturated
  assign ow_raw   = {1'b0, word_r[WORD_W-1:2]} + (SKIP_W + 1)'(|word_r[1:0]);
  assign ow       = ow_raw[SKIP_W] ? SKIP_CAP : ow_raw[SKIP_W-1:0];
  assign skip_dec = (skip_r != '0) ? skip_r - SKIP_W'(1) : skip_r;

  always_comb begin
    fld_code = FC_PAYLOAD;
    pos_adv  = P_BODY;
    len_load = 1'b0;
    len_skip = P_BODY;
    len_next = P_BODY;
    case (pos_r)
      P_XID: begin
        fld_code = FC_XID;
        pos_adv  = P_MTYPE;
      end
      P_MTYPE: begin
        fld_code = FC_MTYPE;
        if (word_r == MSG_CALL) pos_adv = P_RPCVERS;
        else if (word_r == MSG_REPLY) pos_adv = P_STAT;
        else pos_adv = P_STOP;
      end
      P_RPCVERS: begin
        fld_code = FC_RPCVERS;
        pos_adv  = (word_r == RPC_VERSION) ? P_PROG : P_STOP;
      end
      P_PROG: begin
        fld_code = FC_PROG;
        pos_adv  = P_VERS;
      end
      P_VERS: begin
        fld_code = FC_VERS;
        pos_adv  = P_PROC;
      end
      P_PROC: begin
        fld_code = FC_PROC;
        pos_adv  = P_CFLAV;
      end
      P_CFLAV: begin
        fld_code = FC_CRED_FLAV;
        pos_adv  = P_CLEN;
      end
      P_CLEN: begin
        fld_code = FC_CRED_LEN;
        len_load = 1'b1;
        len_skip = P_CSKIP;
        len_next = P_VFLAV;
      end
      P_CSKIP: begin
        pos_adv = (skip_dec != '0) ? P_CSKIP : P_VFLAV;
      end
      P_VFLAV: begin
        fld_code = FC_VERF_FLAV;
        pos_adv  = P_VLEN;
      end
      P_VLEN: begin
        fld_code = FC_VERF_LEN;
        len_load = 1'b1;
        len_skip = P_VSKIP;
        len_next = P_BODY;
      end
      P_VSKIP: begin
        pos_adv = (skip_dec != '0) ? P_VSKIP : P_BODY;
      end
      P_STAT: begin
        fld_code = FC_REPLY_STAT;
        if (word_r == REPLY_ACCEPTED) pos_adv = P_AFLAV;
        else if (word_r == REPLY_DENIED) pos_adv = P_RSTAT;
        else pos_adv = P_BODY;
      end
      P_AFLAV: begin
        fld_code = FC_AVERF_FLAV;
        pos_adv  = P_ALEN;
      end
      P_ALEN: begin
        fld_code = FC_AVERF_LEN;
        len_load = 1'b1;
        len_skip = P_ASKIP;
        len_next = P_ASTAT;
      end
      P_ASKIP: begin
        pos_adv = (skip_dec != '0) ? P_ASKIP : P_ASTAT;
      end
      P_ASTAT: begin
        fld_code = FC_ACC_STAT;
        pos_adv  = (word_r == ACCEPT_PROG_MISM) ? P_PLOW : P_BODY;
      end
      P_PLOW: begin
        fld_code = FC_PROG_LOW;
        pos_adv  = P_PHIGH;
      end
      P_PHIGH: begin
        fld_code = FC_PROG_HIGH;
        pos_adv  = P_BODY;
      end
      P_RSTAT: begin
        fld_code = FC_REJ_STAT;
        if (word_r == REJECT_RPC_MISM) pos_adv = P_RLOW;
        else if (word_r == REJECT_AUTH_ERR) pos_adv = P_AUTH;
        else pos_adv = P_BODY;
      end
      P_RLOW: begin
        fld_code = FC_VERS_LOW;
        pos_adv  = P_RHIGH;
      end
      P_RHIGH: begin
        fld_code = FC_VERS_HIGH;
        pos_adv  = P_BODY;
      end
      P_AUTH: begin
        fld_code = FC_AUTH_STAT;
        pos_adv  = P_BODY;
      end
      P_BODY: begin
        fld_code = FC_PAYLOAD;
        pos_adv  = P_BODY;
      end
      default: begin
        fld_code = FC_PAYLOAD;
        pos_adv  = P_STOP;
      end
    endcase
    if (len_load) begin
      pos_adv = (ow != '0) ? len_skip : len_next;
    end
  end

  always_comb begin
    vb_eff   = (vb_r == '0 || vb_r > VB_W'(4)) ? VB_W'(4) : vb_r;
    is_hdr   = (pos_r != P_BODY) && (pos_r != P_STOP);
    is_skip  = (pos_r == P_CSKIP) || (pos_r == P_VSKIP) || (pos_r == P_ASKIP);
    // a partial last word inside the header is not parsed
    trunc    = fin_r && is_hdr && (vb_eff != VB_W'(4));
    emit_fld = !trunc && ((pos_r == P_BODY) || (is_hdr && !is_skip));
    hdr_step = !trunc && is_hdr;

    pos_new  = hdr_step ? pos_adv : pos_r;
    skip_new = skip_r;
    if (hdr_step && len_load) skip_new = ow;
    else if (hdr_step && is_skip) skip_new = skip_dec;
    hw_new = (hdr_step && hw_r != WORD_CAP) ? hw_r + CNT_W'(1) : hw_r;

    total = {1'b0, words_r, 2'b00} + TOT_W'(vb_eff);
    head  = {1'b0, hw_new, 2'b00};
    rem   = (total > head) ? total - head : '0;

    fld_item.field_code  = fld_code;
    fld_item.field_value = word_r;
    fld_item.status      = ST_OK;
    fld_item.message_end = 1'b0;

    end_item.field_code  = FC_END;
    end_item.message_end = 1'b1;
    if (trunc || (pos_new != P_BODY && pos_new != P_STOP)) begin
      end_item.field_value = '0;
      end_item.status      = ST_TRUNC;
    end else begin
      end_item.field_value = WORD_W'(rem);
      end_item.status      = (pos_new == P_STOP) ? ST_STOPPED : ST_OK;
    end

    item_a = emit_fld ? fld_item : end_item;
    n_push = proc ? (2'(emit_fld) + 2'(fin_r)) : 2'd0;
    qcnt_nxt = qcnt_r + QCNT_W'(n_push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r   <= 1'b0;
      pos_r    <= P_XID;
      skip_r   <= '0;
      words_r  <= '0;
      hw_r     <= '0;
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      qcnt_r   <= '0;
    end else begin
      if (in_ch.ready) begin
        in_v_r <= in_ch.valid;
      end
      if (proc) begin
        if (fin_r) begin
          pos_r   <= P_XID;
          skip_r  <= '0;
          words_r <= '0;
          hw_r    <= '0;
        end else begin
          pos_r   <= pos_new;
          skip_r  <= skip_new;
          hw_r    <= hw_new;
          if (words_r != WORD_CAP) words_r <= words_r + CNT_W'(1);
        end
      end
      wr_ptr_r <= wr_ptr_r + PTR_W'(n_push);
      if (pop) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      qcnt_r <= qcnt_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      word_r <= in_ch.word;
      fin_r  <= in_ch.final_req;
      vb_r   <= in_ch.valid_bytes;
    end
    if (n_push != 2'd0) begin
      queue_r[wr_ptr_r] <= item_a;
    end
    // second entry is always the end record
    if (n_push == 2'd2) begin
      queue_r[wr_ptr_r + PTR_W'(1)] <= end_item;
    end
  end

endmodule

`default_nettype wire

// File: tb/tb_rpc_message_header_parser_unit.sv
// ----------------------------------------------------------------------------
// tb_rpc_message_header_parser_unit
// Self-checking bench for the ONC RPC header parser. A short table of
// hand-picked messages comes first, then random calls, replies, broken and
// truncated messages and one long message. Each accepted word runs
// through a local parser model, and every field that comes out is compared
// with the oldest predicted field.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rpc_message_header_parser_unit;
  import rpc_hdr_pkg::*;

  localparam int unsigned WORD_CAP    = DEF_MAX_MESSAGE_BYTES / 4 - 1;
  localparam int unsigned RAND_WORDS  = 1000;
  localparam int unsigned LONG_WORDS  = 160;

  typedef enum logic [4:0] {
    P_XID, P_MTYPE, P_RPCVERS, P_PROG, P_VERS, P_PROC,
    P_CFLAV, P_CLEN, P_CSKIP, P_VFLAV, P_VLEN, P_VSKIP,
    P_STAT, P_AFLAV, P_ALEN, P_ASKIP, P_ASTAT, P_PLOW, P_PHIGH,
    P_RSTAT, P_RLOW, P_RHIGH, P_AUTH, P_BODY, P_STOP
  } hdr_pos_t;

  typedef struct {
    logic [WORD_W-1:0] word;
    logic              fin;
    logic [VB_W-1:0]   vb;
    bit                typed;
    result_t           want;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;

  rpc_hdr_in_if  in_ch ();
  rpc_hdr_out_if out_ch ();

  rpc_message_header_parser_unit dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // parser model state
  hdr_pos_t          hdr_pos   = P_XID;
  logic [SKIP_W-1:0] skip_left = '0;
  int unsigned       words_in  = 0;
  int unsigned       hdr_words = 0;

  result_t           pending_fields[$];
  dir_row_t          dir_rows[$];
  logic [WORD_W-1:0] msg_words[$];
  int unsigned       burst_left = 0;
  int unsigned       errors     = 0;

  function automatic logic [CODE_W-1:0] code_of(input hdr_pos_t p);
    case (p)
      P_XID:     return FC_XID;
      P_MTYPE:   return FC_MTYPE;
      P_RPCVERS: return FC_RPCVERS;
      P_PROG:    return FC_PROG;
      P_VERS:    return FC_VERS;
      P_PROC:    return FC_PROC;
      P_CFLAV:   return FC_CRED_FLAV;
      P_CLEN:    return FC_CRED_LEN;
      P_VFLAV:   return FC_VERF_FLAV;
      P_VLEN:    return FC_VERF_LEN;
      P_STAT:    return FC_REPLY_STAT;
      P_AFLAV:   return FC_AVERF_FLAV;
      P_ALEN:    return FC_AVERF_LEN;
      P_ASTAT:   return FC_ACC_STAT;
      P_PLOW:    return FC_PROG_LOW;
      P_PHIGH:   return FC_PROG_HIGH;
      P_RSTAT:   return FC_REJ_STAT;
      P_RLOW:    return FC_VERS_LOW;
      P_RHIGH:   return FC_VERS_HIGH;
      P_AUTH:    return FC_AUTH_STAT;
      default:   return FC_PAYLOAD;
    endcase
  endfunction

  // opaque body length in bytes -> words to skip, capped at the counter width
  function automatic hdr_pos_t after_opaque(input logic [WORD_W-1:0] len,
                                            input hdr_pos_t skip_pos, input hdr_pos_t done_pos);
    logic [WORD_W-1:0] n;
    n = (len >> 2) + (len[1:0] != 2'b00);
    skip_left = (n > SKIP_CAP) ? SKIP_CAP : n[SKIP_W-1:0];
    return (skip_left != '0) ? skip_pos : done_pos;
  endfunction

  function automatic hdr_pos_t next_pos(input hdr_pos_t p, input logic [WORD_W-1:0] w);
    case (p)
      P_XID:     return P_MTYPE;
      P_MTYPE:   return (w == MSG_CALL) ? P_RPCVERS : (w == MSG_REPLY) ? P_STAT : P_STOP;
      P_RPCVERS: return (w == RPC_VERSION) ? P_PROG : P_STOP;
      P_PROG:    return P_VERS;
      P_VERS:    return P_PROC;
      P_PROC:    return P_CFLAV;
      P_CFLAV:   return P_CLEN;
      P_CLEN:    return after_opaque(w, P_CSKIP, P_VFLAV);
      P_VFLAV:   return P_VLEN;
      P_VLEN:    return after_opaque(w, P_VSKIP, P_BODY);
      P_STAT:    return (w == REPLY_ACCEPTED) ? P_AFLAV : (w == REPLY_DENIED) ? P_RSTAT : P_BODY;
      P_AFLAV:   return P_ALEN;
      P_ALEN:    return after_opaque(w, P_ASKIP, P_ASTAT);
      P_ASTAT:   return (w == ACCEPT_PROG_MISM) ? P_PLOW : P_BODY;
      P_PLOW:    return P_PHIGH;
      P_RSTAT:   return (w == REJECT_RPC_MISM) ? P_RLOW : (w == REJECT_AUTH_ERR) ? P_AUTH : P_BODY;
      P_RLOW:    return P_RHIGH;
      P_CSKIP, P_VSKIP, P_ASKIP: begin
        if (skip_left != '0) skip_left--;
        if (skip_left != '0) return p;
        return (p == P_CSKIP) ? P_VFLAV : (p == P_VSKIP) ? P_BODY : P_ASTAT;
      end
      default:   return P_BODY;
    endcase
  endfunction

  function automatic void push_field(input logic [CODE_W-1:0] code, input logic [WORD_W-1:0] value,
                                     input logic [STATUS_W-1:0] st, input logic last);
    result_t r;
    r.field_code  = code;
    r.field_value = value;
    r.status      = st;
    r.message_end = last;
    pending_fields.push_back(r);
  endfunction

  // advance the parser model by one accepted word and queue the fields it yields
  function automatic void parse_word(input logic [WORD_W-1:0] w, input logic fin,
                                     input logic [VB_W-1:0] vb_raw);
    hdr_pos_t        p;
    logic [VB_W-1:0] vb;
    int unsigned     total, head;
    p  = hdr_pos;
    vb = (vb_raw == 3'd0 || vb_raw > 3'd4) ? 3'd4 : vb_raw;
    // a partial last word inside the header is dropped unparsed
    if (!(fin && p < P_BODY && vb != 3'd4)) begin
      if (p == P_BODY) begin
        push_field(FC_PAYLOAD, w, ST_OK, 1'b0);
      end else if (p < P_BODY) begin
        if (hdr_words < WORD_CAP) hdr_words++;
        if (p != P_CSKIP && p != P_VSKIP && p != P_ASKIP)
          push_field(code_of(p), w, ST_OK, 1'b0);
        p = next_pos(p, w);
      end
    end
    if (fin) begin
      if (p < P_BODY) begin
        push_field(FC_END, '0, ST_TRUNC, 1'b1);
      end else begin
        total = words_in * 4 + vb;
        head  = hdr_words * 4;
        push_field(FC_END, (total > head) ? total - head : 0,
                   (p == P_STOP) ? ST_STOPPED : ST_OK, 1'b1);
      end
      hdr_pos   = P_XID;
      skip_left = '0;
      words_in  = 0;
      hdr_words = 0;
    end else begin
      hdr_pos = p;
      if (words_in < WORD_CAP) words_in++;
    end
  endfunction

  function automatic void add_row(input logic [WORD_W-1:0] w, input logic fin,
                                  input logic [VB_W-1:0] vb, input bit typed = 1'b0,
                                  input logic [CODE_W-1:0] code = FC_XID,
                                  input logic [WORD_W-1:0] value = '0,
                                  input logic [STATUS_W-1:0] st = ST_OK);
    dir_row_t r;
    r.word              = w;
    r.fin               = fin;
    r.vb                = vb;
    r.typed             = typed;
    r.want.field_code   = code;
    r.want.field_value  = value;
    r.want.status       = st;
    r.want.message_end  = (code == FC_END);
    dir_rows.push_back(r);
  endfunction

  function automatic void push_opaque(input logic [WORD_W-1:0] len);
    repeat ((len + 3) / 4) msg_words.push_back($urandom);
  endfunction

  // one random message, mostly well formed, into msg_words
  function automatic void gen_message();
    int unsigned       kind, pick;
    logic [WORD_W-1:0] len;
    msg_words.delete();
    kind = $urandom_range(0, 9);
    msg_words.push_back($urandom);
    if (kind == 9) begin
      // noise: the message type is random too
      repeat ($urandom_range(0, 5)) msg_words.push_back($urandom);
      return;
    end
    if (kind < 4) begin
      msg_words.push_back(MSG_CALL);
      msg_words.push_back(($urandom_range(0, 7) == 0) ? $urandom : RPC_VERSION);
      repeat (4) msg_words.push_back($urandom);
      if ($urandom_range(0, 24) == 0) begin
        // huge credential body, message ends long before it is skipped
        msg_words.push_back($urandom | 32'h8000_0000);
        repeat ($urandom_range(0, 4)) msg_words.push_back($urandom);
        return;
      end
      len = $urandom_range(0, 24);
      msg_words.push_back(len);
      push_opaque(len);
      msg_words.push_back($urandom);
      len = $urandom_range(0, 24);
      msg_words.push_back(len);
      push_opaque(len);
    end else begin
      msg_words.push_back(MSG_REPLY);
      if (kind < 7) begin
        msg_words.push_back(REPLY_ACCEPTED);
        msg_words.push_back($urandom);
        len = $urandom_range(0, 24);
        msg_words.push_back(len);
        push_opaque(len);
        pick = $urandom_range(0, 3);
        if (pick == 0) begin
          msg_words.push_back(32'd0);
        end else if (pick < 3) begin
          msg_words.push_back(ACCEPT_PROG_MISM);
          msg_words.push_back($urandom);
          msg_words.push_back($urandom);
        end else begin
          msg_words.push_back($urandom);
        end
      end else if (kind == 7) begin
        msg_words.push_back(REPLY_DENIED);
        pick = $urandom_range(0, 2);
        if (pick == 0) begin
          msg_words.push_back(REJECT_RPC_MISM);
          msg_words.push_back($urandom);
          msg_words.push_back($urandom);
        end else if (pick == 1) begin
          msg_words.push_back(REJECT_AUTH_ERR);
          msg_words.push_back($urandom);
        end else begin
          msg_words.push_back($urandom_range(2, 9));
        end
      end else begin
        // unknown reply status ends the header right there
        msg_words.push_back($urandom_range(0, 1) ? $urandom_range(2, 9) : $urandom);
      end
    end
    repeat ($urandom_range(0, 6)) msg_words.push_back($urandom);
  endfunction

  // entered and left at a falling edge; bursts of words with random gaps
  task automatic send_word(input logic [WORD_W-1:0] w, input logic fin,
                           input logic [VB_W-1:0] vb, input bit typed = 1'b0,
                           input result_t want = '0);
    int unsigned gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    in_ch.valid       <= 1'b1;
    in_ch.word        <= w;
    in_ch.final_req   <= fin;
    in_ch.valid_bytes <= vb;
    do @(posedge clk); while (!in_ch.ready);
    parse_word(w, fin, vb);
    if (typed) pending_fields[pending_fields.size() - 1] = want;
    burst_left--;
    @(negedge clk);
  endtask

  function automatic void report(input string what, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
    errors++;
    $display("%0t mismatch on %s: expected %h, actual %h", $time, what, want, got);
  endfunction

  // result checking
  always @(posedge clk) begin
    result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (pending_fields.size() == 0) begin
        errors++;
        $display("%0t unexpected transaction: code %0d value %h status %0d end %b",
                 $time, out_ch.field_code, out_ch.field_value, out_ch.status,
                 out_ch.message_end);
      end else begin
        want = pending_fields.pop_front();
        if (out_ch.field_code !== want.field_code)
          report("field_code", want.field_code, out_ch.field_code);
        if (out_ch.field_value !== want.field_value)
          report("field_value", want.field_value, out_ch.field_value);
        if (out_ch.status !== want.status)
          report("status", want.status, out_ch.status);
        if (out_ch.message_end !== want.message_end)
          report("message_end", want.message_end, out_ch.message_end);
      end
    end
  end

  // receiver stalls, pattern changes every so often
  initial begin
    int unsigned mode, left, phase;
    out_ch.ready <= 1'b0;
    mode  = 0;
    left  = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 200);
      end
      left--;
      phase++;
      case (mode)
        0:       out_ch.ready <= 1'b1;
        1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
        2:       out_ch.ready <= (phase % 4 == 0);
        default: out_ch.ready <= phase[3];
      endcase
    end
  end

  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    dir_row_t    r;
    int unsigned sent, msgs, cut;
    rst_n             <= 1'b0;
    in_ch.valid       <= 1'b0;
    in_ch.word        <= '0;
    in_ch.final_req   <= 1'b0;
    in_ch.valid_bytes <= 3'd4;

    // accepted reply, program mismatch, all-ones and zero words
    add_row(32'hFFFF_FFFF, 1'b0, 3'd4, 1'b1, FC_XID, 32'hFFFF_FFFF);
    add_row(MSG_REPLY, 1'b0, 3'd4, 1'b1, FC_MTYPE, MSG_REPLY);
    add_row(REPLY_ACCEPTED, 1'b0, 3'd4);
    add_row(32'h0000_0000, 1'b0, 3'd4);
    add_row(32'h0000_0000, 1'b0, 3'd4);
    add_row(ACCEPT_PROG_MISM, 1'b0, 3'd4);
    add_row(32'h0000_0000, 1'b0, 3'd4);
    add_row(32'hFFFF_FFFF, 1'b1, 3'd4, 1'b1, FC_END, 32'd0, ST_OK);
    // call with a bad rpc version stops the parse
    add_row(32'h1234_5678, 1'b0, 3'd4);
    add_row(MSG_CALL, 1'b0, 3'd4);
    add_row(32'd3, 1'b0, 3'd4, 1'b1, FC_RPCVERS, 32'd3);
    add_row(32'hAAAA_5555, 1'b1, 3'd2, 1'b1, FC_END, 32'd2, ST_STOPPED);
    // unknown message type, last word with out-of-range byte count
    add_row(32'h0000_0000, 1'b0, 3'd4);
    add_row(32'd7, 1'b0, 3'd4, 1'b1, FC_MTYPE, 32'd7);
    add_row(32'hFFFF_FFFF, 1'b1, 3'd0, 1'b1, FC_END, 32'd4, ST_STOPPED);
    // truncated header, partial last word is not parsed
    add_row(32'h0000_0001, 1'b0, 3'd4);
    add_row(32'h0000_0000, 1'b1, 3'd3, 1'b1, FC_END, 32'd0, ST_TRUNC);
    // one-word message, full last word still parsed
    add_row(32'hDEAD_BEEF, 1'b1, 3'd7, 1'b1, FC_END, 32'd0, ST_TRUNC);
    // denied reply with auth error, then one payload byte
    add_row(32'h0000_0005, 1'b0, 3'd4);
    add_row(MSG_REPLY, 1'b0, 3'd4);
    add_row(REPLY_DENIED, 1'b0, 3'd4);
    add_row(REJECT_AUTH_ERR, 1'b0, 3'd4, 1'b1, FC_REJ_STAT, REJECT_AUTH_ERR);
    add_row(32'h0000_0005, 1'b0, 3'd4);
    add_row(32'h8000_0001, 1'b1, 3'd1, 1'b1, FC_END, 32'd1, ST_OK);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[i]) begin
      r = dir_rows[i];
      send_word(r.word, r.fin, r.vb, r.typed, r.want);
    end

    sent = 0;
    msgs = 0;
    while (sent < RAND_WORDS) begin
      gen_message();
      if ($urandom_range(0, 5) == 0) begin
        cut = $urandom_range(1, msg_words.size());
        while (msg_words.size() > cut) void'(msg_words.pop_back());
      end
      foreach (msg_words[i])
        send_word(msg_words[i], i == msg_words.size() - 1, VB_W'($urandom_range(0, 7)));
      sent += msg_words.size();
      msgs++;
      if (msgs == 40 || $urandom_range(0, 39) == 0) begin
        // hold off until the output side has caught up
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(negedge clk); while (pending_fields.size() != 0);
      end
    end

    // long call with a large payload
    msg_words.delete();
    msg_words.push_back($urandom);
    msg_words.push_back(MSG_CALL);
    msg_words.push_back(RPC_VERSION);
    repeat (4) msg_words.push_back($urandom);
    msg_words.push_back(32'd0);
    msg_words.push_back($urandom);
    msg_words.push_back(32'd0);
    repeat (LONG_WORDS) msg_words.push_back($urandom);
    foreach (msg_words[i])
      send_word(msg_words[i], i == msg_words.size() - 1, VB_W'($urandom_range(0, 7)));

    in_ch.valid <= 1'b0;
    while (pending_fields.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: rpc_message_header_parser_unit.f
rtl/rpc_hdr_pkg.sv
rtl/rpc_hdr_in_if.sv
rtl/rpc_hdr_out_if.sv
rtl/rpc_message_header_parser_unit.sv
tb/tb_rpc_message_header_parser_unit.sv
